>>> hw/rtl/twelve_hour_clock_with_button_set_unit_assert.svh
// Assertion macros shared by the clock unit.
`ifndef TWELVE_HOUR_CLOCK_WITH_BUTTON_SET_UNIT_ASSERT_SVH
`define TWELVE_HOUR_CLOCK_WITH_BUTTON_SET_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define THC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define THC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hw/rtl/thc_pkg.sv
// Shared types, constants and the digit glyph function of the clock unit.
package thc_pkg;

  localparam logic [7:0] SEG_S    = 8'h6D;
  localparam logic [7:0] SEG_P    = 8'h73;
  localparam logic [7:0] SEG_A    = 8'h77;
  localparam logic [7:0] SEG_DASH = 8'h40;
  localparam logic [7:0] SEG_DOT  = 8'h80;
  localparam logic [7:0] SEG_NONE = 8'h00;

  localparam logic [7:0] CFG_LONG_PRESS  = 8'd0;
  localparam logic [7:0] CFG_EXIT_PRESS  = 8'd1;
  localparam logic [7:0] CFG_TIMEOUT     = 8'd2;
  localparam logic [7:0] CFG_VIEW_LENGTH = 8'd3;

  localparam logic [7:0] PRESS_MAX = 8'hFF;

  typedef logic [3:0][7:0] thc_glyphs_t;

  typedef struct packed {
    logic [1:0] quarter_phase;
    logic [3:0] sec_ones;
    logic [2:0] sec_tens;
    logic [3:0] min_ones;
    logic [2:0] min_tens;
    logic [3:0] hr_ones;
    logic       hr_tens;
    logic       pm_flag;
    logic [7:0] press_count;
    logic [2:0] set_mode;
    logic [7:0] idle_count;
    logic [2:0] view_count;
  } thc_state_t;

  typedef struct packed {
    logic [7:0] long_press_count;
    logic [7:0] exit_press_count;
    logic [7:0] setting_timeout;
    logic [2:0] seconds_view_length;
  } thc_cfg_t;

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'd0: g = 8'b00111111;
      4'd1: g = 8'b00000110;
      4'd2: g = 8'b01011011;
      4'd3: g = 8'b01001111;
      4'd4: g = 8'b01100110;
      4'd5: g = 8'b01101101;
      4'd6: g = 8'b01111101;
      4'd7: g = 8'b00000111;
      4'd8: g = 8'b01111111;
      4'd9: g = 8'b01101111;
      default: g = SEG_NONE;
    endcase
    return g;
  endfunction

endpackage

>>> hw/rtl/twelve_hour_clock_with_button_set_unit.sv
// Twelve-hour BCD clock with set button: top level with input and result registers.
// Each beat on the input channel is a quarter-second tick or a button sample;
// each one yields exactly one result beat with the four glyph bytes and the
// time fields. An accepted item waits in the input register and moves into the result
// register once that is free or being drained. One item is taken per cycle while the
// output does not stall; the clock and button state closes its update loop inside
// the core, between the input and result registers. The input stalls only while
// the input register holds an item and the result register is full and stalled.
// Configuration writes are always ready and take effect on the next item.
`include "twelve_hour_clock_with_button_set_unit_assert.svh"
module twelve_hour_clock_with_button_set_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd,
  input  logic       button_down,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] glyph_first,
  output logic [7:0] glyph_second,
  output logic [7:0] glyph_third,
  output logic [7:0] glyph_fourth,
  output logic       hour_tens,
  output logic [3:0] hour_ones,
  output logic [2:0] minute_tens,
  output logic [3:0] minute_ones,
  output logic [2:0] second_tens,
  output logic [3:0] second_ones,
  output logic       afternoon,
  output logic [2:0] setting_step,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import thc_pkg::*;

  thc_cfg_t    cfg;
  logic        s1_valid;
  logic        s1_cmd;
  logic        s1_button;
  logic        step;
  thc_state_t  st;
  thc_state_t  st_next;
  thc_glyphs_t glyphs_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{long_press_count: 8'd5, exit_press_count: 8'd14,
               setting_timeout: 8'd40, seconds_view_length: 3'd4};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LONG_PRESS:  cfg.long_press_count <= cfg_data;
        CFG_EXIT_PRESS:  cfg.exit_press_count <= cfg_data;
        CFG_TIMEOUT:     cfg.setting_timeout <= cfg_data;
        CFG_VIEW_LENGTH: cfg.seconds_view_length <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // The held item moves on whenever the result register is free or being drained.
  assign step = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd <= cmd;
      s1_button <= button_down;
    end
  end

  thc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .cmd         (s1_cmd),
    .button_down (s1_button),
    .cfg         (cfg),
    .st          (st),
    .st_next     (st_next),
    .glyphs_next (glyphs_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      glyph_first  <= glyphs_next[0];
      glyph_second <= glyphs_next[1];
      glyph_third  <= glyphs_next[2];
      glyph_fourth <= glyphs_next[3];
      hour_tens    <= st_next.hr_tens;
      hour_ones    <= st_next.hr_ones;
      minute_tens  <= st_next.min_tens;
      minute_ones  <= st_next.min_ones;
      second_tens  <= st_next.sec_tens;
      second_ones  <= st_next.sec_ones;
      afternoon    <= st_next.pm_flag;
      setting_step <= st_next.set_mode;
    end
  end

  `THC_ASSERT_SAME(a_backpressure_holds_item, s1_valid && out_valid && out_stall, in_stall)
  `THC_ASSERT_NEXT(a_item_reaches_output, s1_valid && !out_valid, out_valid)
  `THC_ASSERT_NEXT(a_tick_advances_phase, step && !s1_cmd,
                   st.quarter_phase == 2'($past(st.quarter_phase) + 2'd1))

endmodule

>>> hw/rtl/thc_display.sv
// Glyph generation for the running and setting views.
module thc_display (
  input  thc_pkg::thc_state_t  st,
  input  logic [2:0]           view_length,
  output thc_pkg::thc_glyphs_t glyphs,
  output logic [2:0]           view_count_next
);
  import thc_pkg::*;

  always_comb begin
    glyphs = '0;
    view_count_next = st.view_count;
    if (st.set_mode == 3'd0) begin
      if (st.view_count != 3'd0) begin
        glyphs[0] = SEG_S;
        glyphs[1] = SEG_NONE;
        glyphs[2] = seg_of({1'b0, st.sec_tens});
        glyphs[3] = seg_of(st.sec_ones);
        if (st.view_count == view_length) begin
          view_count_next = 3'd0;
        end else begin
          view_count_next = st.view_count + 3'd1;
        end
      end else begin
        // Leading hour zero is blanked in the running view.
        glyphs[0] = st.hr_tens ? seg_of({3'b000, st.hr_tens}) : SEG_NONE;
        glyphs[1] = seg_of(st.hr_ones);
        glyphs[2] = seg_of({1'b0, st.min_tens});
        glyphs[3] = seg_of(st.min_ones);
        if (st.pm_flag) begin
          glyphs[0] = glyphs[0] | SEG_DOT;
        end
      end
      if (st.quarter_phase[1]) begin
        glyphs[1] = glyphs[1] | SEG_DOT;
        glyphs[3] = glyphs[3] | SEG_DOT;
      end
    end else begin
      if (st.set_mode < 3'd3) begin
        glyphs[0] = SEG_S;
        glyphs[2] = seg_of({1'b0, st.sec_tens});
        glyphs[3] = seg_of(st.sec_ones);
      end else if (st.set_mode < 3'd7) begin
        glyphs[0] = seg_of({3'b000, st.hr_tens});
        glyphs[1] = seg_of(st.hr_ones);
        glyphs[2] = seg_of({1'b0, st.min_tens});
        glyphs[3] = seg_of(st.min_ones);
      end else begin
        glyphs[0] = st.pm_flag ? SEG_P : SEG_A;
      end
      // The digit under edit blinks on odd quarter phases.
      if (st.quarter_phase[0]) begin
        case (st.set_mode)
          3'd1, 3'd3: glyphs[3] = SEG_NONE;
          3'd2, 3'd4: glyphs[2] = SEG_NONE;
          3'd5:       glyphs[1] = SEG_NONE;
          3'd6, 3'd7: glyphs[0] = SEG_NONE;
          default: ;
        endcase
      end else begin
        glyphs[1] = glyphs[1] | SEG_DOT;
        glyphs[3] = glyphs[3] | SEG_DOT;
      end
    end
  end

endmodule

>>> hw/rtl/thc_core.sv
// Time keeping, button handling and the held glyph state.
module thc_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 cmd,
  input  logic                 button_down,
  input  thc_pkg::thc_cfg_t    cfg,
  output thc_pkg::thc_state_t  st,
  output thc_pkg::thc_state_t  st_next,
  output thc_pkg::thc_glyphs_t glyphs_next
);
  import thc_pkg::*;

  thc_state_t  ev;
  logic        refresh;
  thc_glyphs_t glyphs;
  thc_glyphs_t glyphs_new;
  logic [2:0]  view_count_new;

  always_comb begin
    logic [3:0] so_i;
    logic [2:0] stn_i;
    logic [3:0] mo_i;
    logic [2:0] mt_i;
    logic [3:0] ho_i;
    ev = st;
    refresh = 1'b0;
    so_i = st.sec_ones + 4'd1;
    stn_i = st.sec_tens + 3'd1;
    mo_i = st.min_ones + 4'd1;
    mt_i = st.min_tens + 3'd1;
    ho_i = st.hr_ones + 4'd1;
    if (!cmd) begin
      refresh = 1'b1;
      ev.quarter_phase = st.quarter_phase + 2'd1;
      if (st.quarter_phase == 2'd2) begin
        if (so_i != 4'd10) begin
          ev.sec_ones = so_i;
        end else begin
          ev.sec_ones = 4'd0;
          if (stn_i != 3'd6) begin
            ev.sec_tens = stn_i;
          end else begin
            ev.sec_tens = 3'd0;
            if (mo_i != 4'd10) begin
              ev.min_ones = mo_i;
            end else begin
              ev.min_ones = 4'd0;
              if (mt_i != 3'd6) begin
                ev.min_tens = mt_i;
              end else begin
                ev.min_tens = 3'd0;
                ev.hr_ones = ho_i;
                if (!st.hr_tens && ho_i == 4'd10) begin
                  ev.hr_ones = 4'd0;
                  ev.hr_tens = 1'b1;
                end else if (st.hr_tens && ho_i == 4'd3) begin
                  ev.hr_ones = 4'd1;
                  ev.hr_tens = 1'b0;
                end else if (st.hr_tens && ho_i == 4'd2) begin
                  ev.pm_flag = ~st.pm_flag;
                end
              end
            end
          end
        end
      end
      if (st.press_count != 8'd0 && st.press_count != PRESS_MAX) begin
        ev.press_count = st.press_count + 8'd1;
      end
      if (st.set_mode != 3'd0) begin
        ev.idle_count = st.idle_count + 8'd1;
        if (st.idle_count == cfg.setting_timeout) begin
          ev.set_mode = 3'd0;
        end
      end
    end else if (button_down) begin
      if (st.press_count == 8'd0) begin
        ev.press_count = 8'd1;
        ev.view_count = 3'd1;
        refresh = 1'b1;
      end else if (st.press_count == cfg.long_press_count) begin
        ev.press_count = st.press_count + 8'd1;
        ev.view_count = 3'd0;
        ev.set_mode = st.set_mode + 3'd1;
        ev.idle_count = 8'd1;
        refresh = 1'b1;
      end else if (st.press_count == cfg.exit_press_count) begin
        ev.press_count = st.press_count + 8'd1;
        ev.set_mode = 3'd0;
        refresh = 1'b1;
      end
    end else if (st.press_count != 8'd0) begin
      if (st.press_count < cfg.long_press_count) begin
        refresh = 1'b1;
        if (st.set_mode != 3'd0) begin
          ev.idle_count = 8'd1;
          case (st.set_mode)
            3'd1: ev.sec_ones = (so_i == 4'd10) ? 4'd0 : so_i;
            3'd2: ev.sec_tens = (stn_i == 3'd6) ? 3'd0 : stn_i;
            3'd3: ev.min_ones = (mo_i == 4'd10) ? 4'd0 : mo_i;
            3'd4: ev.min_tens = (mt_i == 3'd6) ? 3'd0 : mt_i;
            3'd5: ev.hr_ones = (ho_i == 4'd10) ? 4'd0 : ho_i;
            3'd6: ev.hr_tens = ~st.hr_tens;
            3'd7: ev.pm_flag = ~st.pm_flag;
            default: ;
          endcase
        end
      end
      ev.press_count = 8'd0;
    end
  end

  thc_display u_display (
    .st              (ev),
    .view_length     (cfg.seconds_view_length),
    .glyphs          (glyphs_new),
    .view_count_next (view_count_new)
  );

  always_comb begin
    st_next = ev;
    glyphs_next = glyphs;
    if (refresh) begin
      st_next.view_count = view_count_new;
      glyphs_next = glyphs_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{quarter_phase: 2'd0, sec_ones: 4'd0, sec_tens: 3'd0, min_ones: 4'd0,
              min_tens: 3'd0, hr_ones: 4'd2, hr_tens: 1'b1, pm_flag: 1'b0,
              press_count: 8'd0, set_mode: 3'd0, idle_count: 8'd0,
              view_count: 3'd0};
      glyphs <= {4{SEG_DASH}};
    end else if (step) begin
      st <= st_next;
      glyphs <= glyphs_next;
    end
  end

endmodule
